### design/bsoc_pkg.sv
// Shared package for the adaptive battery state-of-charge tracker.
// Holds widths, phase codes, register indexes, reset values and the divider structs.
// No dependencies; every other design file imports it.
package bsoc_pkg;

   localparam int VOLT_BITS  = 13;
   localparam int SOC_W      = 7;
   localparam int PHASE_W    = 2;
   localparam int CSR_DATA_W = VOLT_BITS;
   localparam int CSR_IDX_W  = 1;
   localparam int FULL_CHG_W = VOLT_BITS;
   localparam int WIDE_W     = 17;
   localparam int SPAN_W     = VOLT_BITS + 1;
   localparam int PROD_W     = VOLT_BITS + SOC_W;
   localparam int QUOT_W     = 8;
   localparam int DSOR_W     = SPAN_W + QUOT_W - 1;
   localparam int CNT_W      = $clog2(QUOT_W);

   localparam logic [PHASE_W-1:0] PHASE_UNKNOWN     = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_CHARGING    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_DISCHARGING = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_CHARGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BOUND   = 1'd1;

   localparam logic [SOC_W-1:0] SOC_FULL = 7'd100;

   localparam logic [FULL_CHG_W-1:0] FULL_CHARGE_RST = FULL_CHG_W'(4200);
   localparam logic [SOC_W-1:0]      LOW_BOUND_RST   = 7'd20;
   localparam logic [VOLT_BITS-1:0]  FULL_LEVEL_RST  = VOLT_BITS'(3900);
   localparam logic [VOLT_BITS-1:0]  EMPTY_LEVEL_RST = VOLT_BITS'(3500);
   localparam logic [VOLT_BITS-1:0]  OFFSET_RST      = VOLT_BITS'(300);

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [SPAN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_sts_type;

endpackage

### design/bsoc_if.sv
// Valid/ready channel interfaces for the sample and result transactions.
// Depends on bsoc_pkg for the payload widths.
interface bsoc_req_if;
   import bsoc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VOLT_BITS-1:0] sample_mv;
   logic                 is_charging;
   modport source (output valid, output sample_mv, output is_charging, input ready);
   modport sink (input valid, input sample_mv, input is_charging, output ready);
endinterface

interface bsoc_rsp_if;
   import bsoc_pkg::*;
   logic               valid;
   logic               ready;
   logic [SOC_W-1:0]   soc_percent;
   logic               low_charge;
   logic [PHASE_W-1:0] phase;
   modport source (output valid, output soc_percent, output low_charge, output phase,
                   input ready);
   modport sink (input valid, input soc_percent, input low_charge, input phase,
                 output ready);
endinterface

### design/bsoc_divider.sv
// Shared restoring shift-subtract divider, one quotient bit per cycle.
// Depends on bsoc_pkg; a quotient with its top bit set means 128 or more.
module bsoc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  bsoc_pkg::div_req_type  div_req,
   output bsoc_pkg::div_sts_type  div_sts
);
   import bsoc_pkg::*;

   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [DSOR_W-1:0] ds_ff, ds_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ge;

   assign ge = {{(DSOR_W-PROD_W){1'b0}}, rem_ff} >= ds_ff;

   always_comb begin
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         ds_in   = {div_req.divisor, {(QUOT_W-1){1'b0}}};
         q_in    = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = PROD_W'({{(DSOR_W-PROD_W){1'b0}}, rem_ff} - ds_ff);
         end
         q_in   = {q_ff[QUOT_W-2:0], ge};
         ds_in  = ds_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_sts.done = done_ff;
   assign div_sts.quot = q_ff;

endmodule

### design/adaptive_battery_soc_tracker.sv
// Top level of the adaptive battery state-of-charge tracker: sequencer and learned state.
// Depends on bsoc_pkg, bsoc_if and bsoc_divider.
// Each sample transaction returns exactly one result transaction carrying the state of
// charge in percent (0 to 100), a sticky low-power flag and the phase. The learned levels
// update at acceptance; then the PREP state forms the numerator and span, the shared
// divider runs at one quotient bit per cycle, the DIV state waits for the divider's done
// flag, and the FIN state saturates and registers the result, holding there while the
// output register is still full. The block takes no new sample until it is back in idle,
// but it does accept one while an earlier result still waits in the output register.
// Configuration writes are meant to happen only while no sample is in flight.
module adaptive_battery_soc_tracker (
   input  logic                             clock,
   input  logic                             reset,
   bsoc_req_if.sink                         req_ch,
   bsoc_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsoc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bsoc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [FULL_CHG_W-1:0] full_charge_ff;
   logic [SOC_W-1:0]      low_bound_ff;
   logic [VOLT_BITS-1:0]  full_ff, full_in;
   logic [VOLT_BITS-1:0]  empty_ff, empty_in;
   logic [VOLT_BITS-1:0]  offset_ff, offset_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [SOC_W-1:0]      last_soc_ff;
   logic                  low_flag_ff;
   logic [VOLT_BITS-1:0]  sample_ff;
   logic                  span_zero_ff;
   logic                  rsp_valid_ff;
   logic [SOC_W-1:0]      rsp_soc_ff;
   logic                  rsp_low_ff;
   logic [PHASE_W-1:0]    rsp_phase_ff;

   logic                  req_take;
   logic                  rsp_free;
   logic                  fin_load;
   logic [WIDE_W-1:0]     chg_wide;
   logic [WIDE_W-1:0]     smp_wide;
   logic [VOLT_BITS-1:0]  num;
   logic [SPAN_W-1:0]     span;
   logic [SOC_W-1:0]      soc;
   logic                  low_next;
   div_req_type           div_req;
   div_sts_type           div_sts;

   bsoc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fin_load     = (state_ff == ST_FIN) && rsp_free;

   assign chg_wide = {{(WIDE_W-FULL_CHG_W){1'b0}}, full_charge_ff};
   assign smp_wide = {{(WIDE_W-VOLT_BITS){1'b0}}, req_ch.sample_mv};

   always_comb begin
      full_in   = full_ff;
      empty_in  = empty_ff;
      offset_in = offset_ff;
      phase_in  = phase_ff;
      if (req_ch.is_charging) begin
         phase_in = PHASE_CHARGING;
         if (req_ch.sample_mv > full_ff) begin
            full_in = req_ch.sample_mv;
         end
      end else begin
         if (phase_ff == PHASE_CHARGING && last_soc_ff == SOC_FULL) begin
            full_in   = req_ch.sample_mv;
            offset_in = (chg_wide > smp_wide) ? VOLT_BITS'(chg_wide - smp_wide) : '0;
         end
         phase_in = PHASE_DISCHARGING;
         if (req_ch.sample_mv < empty_ff) begin
            empty_in = req_ch.sample_mv;
         end
      end
   end

   always_comb begin
      num  = (sample_ff > empty_ff) ? VOLT_BITS'(sample_ff - empty_ff) : '0;
      span = (full_ff > empty_ff) ? SPAN_W'(full_ff - empty_ff) : '0;
      if (phase_ff == PHASE_CHARGING) begin
         span = span + {1'b0, offset_ff};
      end
      div_req.start    = (state_ff == ST_PREP);
      div_req.dividend = PROD_W'(num) * PROD_W'(SOC_FULL);
      div_req.divisor  = span;
   end

   always_comb begin
      if (span_zero_ff || div_sts.quot > {1'b0, SOC_FULL}) begin
         soc = SOC_FULL;
      end else begin
         soc = div_sts.quot[SOC_W-1:0];
      end
      low_next = low_flag_ff || (soc < low_bound_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_ch.sample_mv;
      end
      if (state_ff == ST_PREP) begin
         span_zero_ff <= (span == '0);
      end
      if (fin_load) begin
         rsp_soc_ff   <= soc;
         rsp_low_ff   <= low_next;
         rsp_phase_ff <= phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         full_charge_ff <= FULL_CHARGE_RST;
         low_bound_ff   <= LOW_BOUND_RST;
         full_ff        <= FULL_LEVEL_RST;
         empty_ff       <= EMPTY_LEVEL_RST;
         offset_ff      <= OFFSET_RST;
         phase_ff       <= PHASE_UNKNOWN;
         last_soc_ff    <= '0;
         low_flag_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FULL_CHARGE: full_charge_ff <= FULL_CHG_W'(csr_wdata);
               CSR_LOW_BOUND:   low_bound_ff   <= csr_wdata[SOC_W-1:0];
               default:         ;
            endcase
         end
         if (req_take) begin
            full_ff   <= full_in;
            empty_ff  <= empty_in;
            offset_ff <= offset_in;
            phase_ff  <= phase_in;
         end
         if (fin_load) begin
            last_soc_ff  <= soc;
            low_flag_ff  <= low_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.soc_percent = rsp_soc_ff;
   assign rsp_ch.low_charge  = rsp_low_ff;
   assign rsp_ch.phase       = rsp_phase_ff;

endmodule

### design/bsoc_checker.sv
// Port-level checker for the state-of-charge tracker, bound to the top level.
// Depends on bsoc_pkg for widths and phase codes.
module bsoc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bsoc_pkg::SOC_W-1:0]     soc_percent,
   input logic                           low_charge,
   input logic [bsoc_pkg::PHASE_W-1:0]   phase
);
   import bsoc_pkg::*;

   logic seen_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_low_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && low_charge) begin
         seen_low_ff <= 1'b1;
      end
   end

   a_soc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> soc_percent <= SOC_FULL)
      else $error("state of charge above full");

   a_phase_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (phase == PHASE_CHARGING || phase == PHASE_DISCHARGING))
      else $error("result carries unknown phase");

   a_low_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && seen_low_ff) |-> low_charge)
      else $error("low-power flag cleared without reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after an accepted transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(soc_percent))
      else $error("stalled result changed");

endmodule

bind adaptive_battery_soc_tracker bsoc_checker u_bsoc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .soc_percent (rsp_ch.soc_percent),
   .low_charge  (rsp_ch.low_charge),
   .phase       (rsp_ch.phase)
);
